FILE: hw/rtl/union_find_path_compression_defines.svh
// Assertion macros shared by the union-find RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef UNION_FIND_PATH_COMPRESSION_DEFINES_SVH
`define UNION_FIND_PATH_COMPRESSION_DEFINES_SVH

`ifndef SYNTHESIS

`define UFPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define UFPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define UFPC_ASSERT(lbl, prop, msg)

`define UFPC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/ufpc_pkg.sv
// Shared types and constants of the union-find engine.
// Depends on nothing; imported by the parent table RAM and the top level.
package ufpc_pkg;

  localparam int unsigned NODES = 1024;
  localparam int unsigned IDX_W = $clog2(NODES);

  typedef logic [IDX_W-1:0] idx_t;

  localparam logic CMD_UNION = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic we;
    idx_t waddr;
    idx_t wdata;
    idx_t raddr;
  } mem_req_t;

endpackage

FILE: hw/rtl/ufpc_ram.sv
// Parent table: one write port and one registered read port.
// Depends on ufpc_pkg.
module ufpc_ram (
  input  logic              clk_i,
  input  ufpc_pkg::mem_req_t req_i,
  output ufpc_pkg::idx_t    rdata_o
);
  import ufpc_pkg::*;

  idx_t mem_q [NODES];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

FILE: hw/rtl/union_find_path_compression.sv
// Union-find engine with path compression over a parent table in RAM.
// Depends on ufpc_pkg, ufpc_ram and union_find_path_compression_defines.svh.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   request  | in_valid_i, in_stall_o, command_i,        | in
//            | node_a_i, node_b_i                        |
//   result   | out_valid_o, out_stall_i, same_set_o,     | out
//            | root_a_o                                  |
//
// After reset a clearing pass sets every entry to its own index; no beat is
// accepted during it. An item walks from node a to its root and compresses that
// path, then does the same for node b; every link is a read on the single RAM
// read port. A finished result waits in the output register; a new beat is
// taken once that result has been loaded.
`include "union_find_path_compression_defines.svh"

module union_find_path_compression (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            command_i,
  input  ufpc_pkg::idx_t  node_a_i,
  input  ufpc_pkg::idx_t  node_b_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            same_set_o,
  output ufpc_pkg::idx_t  root_a_o
);
  import ufpc_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_COMP  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_q, state_d;
  idx_t       clr_q, clr_d;
  logic       phase_b_q, phase_b_d;
  idx_t       cur_q, cur_d;
  idx_t       root_q, root_d;
  idx_t       root_a_q, root_a_d;
  logic       cmd_q;
  idx_t       a_q, b_q;
  logic       out_valid_q, out_valid_d;
  logic       same_set_q;
  idx_t       root_out_q;
  logic       out_load;
  idx_t       start;
  idx_t       rdata;
  mem_req_t   mem_req;

  ufpc_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign start       = phase_b_q ? b_q : a_q;
  assign out_valid_o = out_valid_q;
  assign same_set_o  = same_set_q;
  assign root_a_o    = root_out_q;

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    phase_b_d     = phase_b_q;
    cur_d         = cur_q;
    root_d        = root_q;
    root_a_d      = root_a_q;
    out_load      = 1'b0;
    mem_req       = '0;
    mem_req.raddr = cur_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_q;
        mem_req.wdata = clr_q;
        clr_d         = clr_q + 1'b1;
        if (clr_q == idx_t'(NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cur_d         = node_a_i;
          mem_req.raddr = node_a_i;
          phase_b_d     = 1'b0;
          state_d       = ST_WALK;
        end
      end
      ST_WALK: begin
        if (rdata == cur_q) begin
          root_d        = cur_q;
          cur_d         = start;
          mem_req.raddr = start;
          state_d       = ST_COMP;
        end else begin
          cur_d         = rdata;
          mem_req.raddr = rdata;
        end
      end
      ST_COMP: begin
        if (cur_q != root_q) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cur_q;
          mem_req.wdata = root_q;
          cur_d         = rdata;
          mem_req.raddr = rdata;
        end else if (!phase_b_q) begin
          root_a_d      = root_q;
          phase_b_d     = 1'b1;
          cur_d         = b_q;
          mem_req.raddr = b_q;
          state_d       = ST_WALK;
        end else begin
          if (cmd_q == CMD_UNION && root_a_q != root_q) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = root_q;
            mem_req.wdata = root_a_q;
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      phase_b_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      phase_b_q   <= phase_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    root_q   <= root_d;
    root_a_q <= root_a_d;
    if (state_q == ST_IDLE && in_valid_i) begin
      cmd_q <= command_i;
      a_q   <= node_a_i;
      b_q   <= node_b_i;
    end
    if (out_load) begin
      same_set_q <= (root_a_q == root_q);
      root_out_q <= root_a_q;
    end
  end

  `UFPC_ASSERT_NEXT(a_accept_walk, in_valid_i && !in_stall_o, state_q == ST_WALK,
    "Accepted beat did not start a walk.")
  `UFPC_ASSERT(a_comp_no_clash,
    (state_q == ST_COMP && cur_q != root_q) |-> (mem_req.raddr != mem_req.waddr),
    "Compression write and read hit the same entry.")
  `UFPC_ASSERT(a_no_stray_write,
    (state_q == ST_IDLE || state_q == ST_WALK || state_q == ST_OUT) |-> !mem_req.we,
    "Parent table written outside clearing or compression.")
  `UFPC_ASSERT(a_load_from_out,
    $rose(out_valid_q) |-> ($past(state_q) == ST_OUT),
    "Result register loaded outside the result state.")

endmodule

FILE: sim/union_find_checker.sv
// Result checker for the union-find engine: predicts each result from a private parent table.
// Depends on ufpc_pkg; instantiated by tb beside the engine and watches both channels.
module union_find_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             command_i,
  input  ufpc_pkg::idx_t   node_a_i,
  input  ufpc_pkg::idx_t   node_b_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic             same_set_i,
  input  ufpc_pkg::idx_t   root_a_i,
  output int unsigned      mismatches_o,
  output int unsigned      backlog_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ufpc_pkg::*;

  typedef struct packed {
    logic same;
    idx_t root;
  } outcome_t;

  idx_t        links [NODES];
  outcome_t    awaited_results [$];
  int unsigned mismatch_count = 0;

  function automatic idx_t trace_root(input idx_t start);
    idx_t top;
    idx_t walk;
    idx_t nxt;
    int   steps;
    top = start;
    steps = 0;
    while (steps < NODES && links[top] != top) begin
      top = links[top];
      steps++;
    end
    walk = start;
    steps = 0;
    while (steps < NODES && walk != top) begin
      nxt = links[walk];
      links[walk] = top;
      walk = nxt;
      steps++;
    end
    return top;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    idx_t     ra;
    idx_t     rb;
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) links[i] = idx_t'(i);
      awaited_results.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing outstanding: same_set %0b root_a %0d",
                   $time, same_set_i, root_a_i);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (want.same != same_set_i) begin
            $display("%0t: same_set expected %0b actual %0b", $time, want.same, same_set_i);
            mismatch_count++;
          end
          if (want.root != root_a_i) begin
            $display("%0t: root_a expected %0d actual %0d", $time, want.root, root_a_i);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        ra = trace_root(node_a_i);
        rb = trace_root(node_b_i);
        if (command_i == CMD_UNION && ra != rb) links[rb] = ra;
        want.same = (ra == rb);
        want.root = ra;
        awaited_results.insert(awaited_results.size(), want);
      end
    end
    mismatches_o <= mismatch_count;
    backlog_o <= awaited_results.size();
  end

endmodule

FILE: sim/tb.sv
// Top of the union-find testbench: clock, reset, request stimulus and result back-pressure.
// Depends on ufpc_pkg, union_find_path_compression and union_find_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ufpc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = CMD_UNION;
  idx_t        node_a = '0;
  idx_t        node_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        same_set;
  idx_t        root_a;
  logic        calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned mismatches;
  int unsigned backlog;

  union_find_path_compression dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .command_i   (command),
    .node_a_i    (node_a),
    .node_b_i    (node_b),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .same_set_o  (same_set),
    .root_a_o    (root_a)
  );

  union_find_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .command_i    (command),
    .node_a_i     (node_a),
    .node_b_i     (node_b),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .same_set_i   (same_set),
    .root_a_i     (root_a),
    .mismatches_o (mismatches),
    .backlog_o    (backlog)
  );

  always #5 clk_i = ~clk_i;

  // Each result beat draws how long the next one is held off.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned hold;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      hold = calm ? 0 : $urandom_range(0, 15);
      out_stall <= (hold != 0);
      stall_left <= (hold != 0) ? hold - 1 : 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic offer(input logic cmd, input idx_t a, input idx_t b);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    command <= cmd;
    node_a <= a;
    node_b <= b;
    do @(posedge clk_i); while (in_stall);
  endtask

  function automatic idx_t pick_node(input int unsigned base, input int unsigned span);
    if ($urandom_range(0, 19) == 0) return ($urandom_range(0, 1) != 0) ? idx_t'(NODES - 1) : '0;
    return idx_t'(base + $urandom_range(0, span - 1));
  endfunction

  initial begin
    int unsigned left;
    int unsigned stretch;
    int unsigned style;
    int unsigned span;
    int unsigned base;
    idx_t        a;
    idx_t        b;
    idx_t        tail;
    idx_t        head;
    logic        cmd;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    offer(CMD_QUERY, '0, idx_t'(NODES - 1));
    offer(CMD_UNION, '0, idx_t'(NODES - 1));
    offer(CMD_QUERY, idx_t'(NODES - 1), '0);
    offer(CMD_UNION, idx_t'(NODES - 1), '0);
    offer(CMD_UNION, idx_t'(5), idx_t'(5));
    offer(CMD_QUERY, idx_t'(NODES - 1), idx_t'(NODES - 1));
    for (int i = 0; i < 10; i++) offer(CMD_UNION, idx_t'(101 + i), idx_t'(100 + i));
    offer(CMD_QUERY, idx_t'(100), idx_t'(110));
    offer(CMD_QUERY, idx_t'(100), idx_t'(110));
    offer(CMD_UNION, idx_t'(110), idx_t'(100));
    offer(CMD_UNION, idx_t'(10'h2AA), idx_t'(10'h155));
    offer(CMD_QUERY, idx_t'(10'h155), idx_t'(10'h2AA));
    offer(CMD_UNION, idx_t'(10'h155), idx_t'(105));
    offer(CMD_QUERY, idx_t'(100), idx_t'(10'h2AA));

    left = 530;
    while (left > 0) begin
      style = $urandom_range(0, 3);
      stretch = $urandom_range(10, 40);
      calm <= ($urandom_range(0, 3) == 0);
      case (style)
        0: span = 8;
        1: span = 64;
        default: span = NODES;
      endcase
      base = $urandom_range(0, NODES - span);
      head = idx_t'($urandom_range(0, NODES - 1));
      tail = head;
      for (int k = 0; k < stretch && left > 0; k++) begin
        if (style == 3) begin
          // Grow a long chain so that later finds walk and compress deep paths.
          if (k % 8 == 7) begin
            offer(CMD_QUERY, head, tail);
          end else begin
            a = idx_t'($urandom_range(0, NODES - 1));
            offer(CMD_UNION, a, tail);
            tail = a;
          end
        end else begin
          cmd = ($urandom_range(0, 9) < 4) ? CMD_QUERY : CMD_UNION;
          a = pick_node(base, span);
          b = ($urandom_range(0, 9) == 0) ? a : pick_node(base, span);
          offer(cmd, a, b);
        end
        left--;
      end
    end

    in_valid <= 1'b0;
    calm <= 1'b0;
    @(posedge clk_i);
    wait (backlog == 0);
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ufpc_pkg.sv
hw/rtl/ufpc_ram.sv
hw/rtl/union_find_path_compression.sv
sim/union_find_checker.sv
sim/tb.sv
